// File: hw/rtl/rbsr_pkg.sv
// Shared constants, codes and helpers for the ragged bilinear strip resampler.
// No dependencies; every other file in hw/rtl refers to this package by scope.
package rbsr_pkg;

  localparam int MAX_CHANNELS_DEF = 64;
  localparam int MAX_LEN_DEF      = 1024;

  localparam int IDX_W   = 12;   // pixel row / column
  localparam int STRIP_W = 13;   // strip width / height registers
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 16;   // Q0.16 weight
  localparam int CH_W    = 6;
  localparam int POS_W   = 10;
  localparam int NCH_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STRIP_MAX = 4096;

  // Request kinds
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_LEN   = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_HEIGHT = 2'd2;

  localparam logic [NCH_W-1:0]   NUM_CHANNELS_RST = 7'd1;
  localparam logic [STRIP_W-1:0] STRIP_SIZE_RST   = 13'd256;

  // Saturate a strip size into 1..4096.
  function automatic logic [STRIP_W-1:0] clamp_strip(input logic [STRIP_W-1:0] v);
    logic [STRIP_W-1:0] r;
    if (v == '0) begin
      r = STRIP_W'(1);
    end else if (32'(v) > STRIP_MAX) begin
      r = STRIP_W'(STRIP_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rbsr_req_if.sv
// Request channel: valid/ready handshake with one request beat.
// Depends on rbsr_pkg for field widths.
interface rbsr_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [rbsr_pkg::CH_W-1:0]   channel;
  logic [rbsr_pkg::POS_W-1:0]  position;
  logic [rbsr_pkg::COEF_W-1:0] value;
  logic [rbsr_pkg::IDX_W-1:0]  pixel_row;
  logic [rbsr_pkg::IDX_W-1:0]  pixel_col;

  modport source (output valid, req_type, channel, position, value, pixel_row, pixel_col,
                  input ready);
  modport sink (input valid, req_type, channel, position, value, pixel_row, pixel_col,
                output ready);
endinterface

// Pixel channel: valid/ready handshake with one pixel beat.
interface rbsr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rbsr_pkg::COEF_W-1:0] pixel_value;
  logic [rbsr_pkg::IDX_W-1:0]  row_out;
  logic [rbsr_pkg::IDX_W-1:0]  col_out;

  modport source (output valid, pixel_value, row_out, col_out, input ready);
  modport sink (input valid, pixel_value, row_out, col_out, output ready);
endinterface

// File: hw/rtl/ragged_bilinear_strip_resampler_top.sv
// Top level of the ragged bilinear strip resampler: request decode, length table,
// coefficient store and interpolation pipeline. Depends on rbsr_pkg, the interfaces, rbsr_div.
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------------
//   req      | in  | req_type, channel, position, value, pixel_row, pixel_col
//   pix      | out | pixel_value, row_out, col_out (pixel requests only)
//   cfg_*    | in  | write enable, register index, data (no handshake)
//
// One request beat per cycle sustained while pix takes its beats and no clearing
// sweep runs. The two dividers resolve one quotient bit per stage. After reset
// the coefficient store is swept to zero over all MAX_CHANNELS * MAX_LEN entries
// (65536 by default), with req.ready low. A stall on pix freezes the whole
// pipeline in place; req.ready follows the output register.
module ragged_bilinear_strip_resampler_top #(
  parameter int MAX_CHANNELS = rbsr_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_LEN      = rbsr_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rbsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbsr_pkg::STRIP_W-1:0]      cfg_data,
  rbsr_req_if.sink                          req,
  rbsr_pix_if.source                        pix
);
  localparam int CW    = $clog2(MAX_CHANNELS);     // channel index
  localparam int MW    = $clog2(MAX_CHANNELS + 1); // channel count
  localparam int LW    = $clog2(MAX_LEN);          // coefficient index
  localparam int LNW   = $clog2(MAX_LEN + 1);      // channel length
  localparam int DEPTH = MAX_CHANNELS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = rbsr_pkg::IDX_W;
  localparam int SW    = rbsr_pkg::STRIP_W;
  localparam int KW    = rbsr_pkg::COEF_W;
  localparam int FW    = rbsr_pkg::FRAC_W;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [rbsr_pkg::CH_W-1:0]  ch;
    logic [rbsr_pkg::POS_W-1:0] pos;
    logic [KW-1:0]              val;
    logic [IW-1:0]              row;
    logic [IW-1:0]              col;
    logic                       m1;   // single channel: interpolate along rows only
    logic [SW-1:0]              w;
    logic [SW-1:0]              h;
    logic [CW-1:0]              ylo;
    logic [CW-1:0]              yhi;
    logic [FW-1:0]              fy;
  } item_t;

  // Configuration registers
  logic [rbsr_pkg::NCH_W-1:0] num_channels;
  logic [SW-1:0]              strip_width;
  logic [SW-1:0]              strip_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= rbsr_pkg::NUM_CHANNELS_RST;
      strip_width  <= rbsr_pkg::STRIP_SIZE_RST;
      strip_height <= rbsr_pkg::STRIP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbsr_pkg::CFG_NUM_CHANNELS: num_channels <= cfg_data[rbsr_pkg::NCH_W-1:0];
        rbsr_pkg::CFG_STRIP_WIDTH:  strip_width  <= cfg_data;
        rbsr_pkg::CFG_STRIP_HEIGHT: strip_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: move everything when the output slot is free or drains.
  logic adv;
  logic vo;
  logic clr_busy;
  logic [AW-1:0] clr_addr;

  assign adv       = !vo || pix.ready;
  assign req.ready = adv && !clr_busy;

  // Clearing sweep of the coefficient store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= AW'(clr_addr + 1'b1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------- S0: capture beat, saturate registers ----------------
  logic [MW-1:0] m_c;
  always_comb begin
    if (num_channels == '0) begin
      m_c = MW'(1);
    end else if (32'(num_channels) > MAX_CHANNELS) begin
      m_c = MW'(MAX_CHANNELS);
    end else begin
      m_c = MW'(num_channels);
    end
  end

  logic          v0;
  item_t         it0;
  logic [CW-1:0] span0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= req.valid && req.ready;
    end
    if (adv) begin
      it0.kind <= req.req_type;
      it0.ch   <= req.channel;
      it0.pos  <= req.position;
      it0.val  <= req.value;
      it0.row  <= req.pixel_row;
      it0.col  <= req.pixel_col;
      it0.m1   <= (m_c == MW'(1));
      it0.w    <= rbsr_pkg::clamp_strip(strip_width);
      it0.h    <= rbsr_pkg::clamp_strip(strip_height);
      it0.ylo  <= '0;
      it0.yhi  <= '0;
      it0.fy   <= '0;
      span0    <= CW'(m_c - MW'(1));
    end
  end

  // ---------------- S1: row * (channels-1) ----------------
  logic             v1;
  item_t            it1;
  logic [IW+CW-1:0] prod_y;
  logic             sat_y;
  logic [CW-1:0]    span1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      it1    <= it0;
      prod_y <= (IW+CW)'(it0.row) * (IW+CW)'(span0);
      // With one channel the span is zero and saturation pins both rows to 0.
      sat_y  <= it0.m1 || ({1'b0, it0.row} >= it0.h);
      span1  <= span0;
    end
  end

  // ---------------- vertical divider ----------------
  logic              vy;
  logic [CW-1:0]     ylo_d;
  logic [CW-1:0]     yhi_d;
  logic [FW-1:0]     fy_d;
  logic [$bits(item_t)-1:0] pay_y;
  item_t             it_y;

  rbsr_div #(.SPAN_W(CW), .PW($bits(item_t))) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v1),
    .prod     (prod_y),
    .dvs      (it1.h),
    .sat      (sat_y),
    .span     (span1),
    .pay      (it1),
    .out_valid(vy),
    .lo       (ylo_d),
    .hi       (yhi_d),
    .frac     (fy_d),
    .out_pay  (pay_y)
  );
  assign it_y = pay_y;

  // ---------------- S2: channel length table ----------------
  logic [LNW-1:0]          len_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] len_vld;
  logic [LNW-1:0]          len_rd;
  logic                    len_ok;
  logic                    v2;
  item_t                   it2;
  item_t                   it2_next;
  logic [CW-1:0]           len_widx;
  logic                    len_we;
  logic [LNW-1:0]          len_c;

  assign len_widx = CW'(it_y.ch);
  assign len_we   = adv && vy && (it_y.kind == rbsr_pkg::REQ_LEN)
                    && (32'(it_y.ch) < MAX_CHANNELS);

  always_comb begin
    if (it_y.val < KW'(2)) begin
      len_c = LNW'(2);
    end else if (32'(it_y.val) > MAX_LEN) begin
      len_c = LNW'(MAX_LEN);
    end else begin
      len_c = LNW'(it_y.val);
    end
  end

  // An entry never written reads as length two.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (len_we) begin
      len_vld[len_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_widx] <= len_c;
    end
    if (adv) begin
      len_rd <= len_mem[ylo_d];
      len_ok <= len_vld[ylo_d];
    end
  end

  // Attach the vertical position to the beat.
  always_comb begin
    it2_next     = it_y;
    it2_next.ylo = ylo_d;
    it2_next.yhi = yhi_d;
    it2_next.fy  = fy_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= vy;
    end
    if (adv) begin
      it2 <= it2_next;
    end
  end

  // ---------------- S3: index * (length-1) ----------------
  logic [LNW-1:0]   len_use;
  logic [LW-1:0]    span_x;
  logic [IW-1:0]    idx_x;
  logic [SW-1:0]    dv_x;
  logic             v3;
  item_t            it3;
  logic [IW+LW-1:0] prod_x;
  logic             sat_x;
  logic [LW-1:0]    span3;
  logic [SW-1:0]    dv3;

  assign len_use = len_ok ? len_rd : LNW'(2);
  assign span_x  = LW'(len_use - LNW'(1));
  // One channel: the row runs along the coefficients of channel 0.
  assign idx_x   = it2.m1 ? it2.row : it2.col;
  assign dv_x    = it2.m1 ? it2.h : it2.w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      it3    <= it2;
      prod_x <= (IW+LW)'(idx_x) * (IW+LW)'(span_x);
      sat_x  <= ({1'b0, idx_x} >= dv_x);
      span3  <= span_x;
      dv3    <= dv_x;
    end
  end

  // ---------------- horizontal divider ----------------
  logic              vx;
  logic [LW-1:0]     xlo_d;
  logic [LW-1:0]     xhi_d;
  logic [FW-1:0]     fx_d;
  logic [$bits(item_t)-1:0] pay_x;
  item_t             it_x;

  rbsr_div #(.SPAN_W(LW), .PW($bits(item_t))) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v3),
    .prod     (prod_x),
    .dvs      (dv3),
    .sat      (sat_x),
    .span     (span3),
    .pay      (it3),
    .out_valid(vx),
    .lo       (xlo_d),
    .hi       (xhi_d),
    .frac     (fx_d),
    .out_pay  (pay_x)
  );
  assign it_x = pay_x;

  // ---------------- S4: store addresses ----------------
  logic [AW-1:0] base_lo;
  logic [AW-1:0] base_hi;
  logic          v4;
  item_t         it4;
  logic [FW-1:0] fx4;
  logic [AW-1:0] a00, a01, a10, a11, wa4;
  logic          we4;

  assign base_lo = AW'(AW'(it_x.ylo) * AW'(MAX_LEN));
  assign base_hi = AW'(AW'(it_x.yhi) * AW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= vx;
    end
    if (adv) begin
      it4 <= it_x;
      fx4 <= fx_d;
      a00 <= AW'(base_lo + AW'(xlo_d));
      a01 <= AW'(base_lo + AW'(xhi_d));
      a10 <= AW'(base_hi + AW'(xlo_d));
      a11 <= AW'(base_hi + AW'(xhi_d));
      wa4 <= AW'(AW'(AW'(it_x.ch) * AW'(MAX_LEN)) + AW'(it_x.pos));
      // Drop loads aimed outside the store.
      we4 <= (it_x.kind == rbsr_pkg::REQ_LOAD) && (32'(it_x.ch) < MAX_CHANNELS)
             && (32'(it_x.pos) < MAX_LEN);
    end
  end

  // ---------------- S5: coefficient store, two copies of two read ports ----------------
  logic [KW-1:0] mem_a [DEPTH];
  logic [KW-1:0] mem_b [DEPTH];
  logic [KW-1:0] c00, c01, c10, c11;
  logic          v5;
  item_t         it5;
  logic [FW-1:0] fx5;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem_a[clr_addr] <= '0;
      mem_b[clr_addr] <= '0;
    end else if (adv && v4 && we4) begin
      mem_a[wa4] <= it4.val;
      mem_b[wa4] <= it4.val;
    end
    if (adv) begin
      c00 <= mem_a[a00];
      c01 <= mem_a[a01];
      c10 <= mem_b[a10];
      c11 <= mem_b[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      it5 <= it4;
      fx5 <= fx4;
    end
  end

  // ---------------- S6: horizontal weight products ----------------
  // lerp(a,b,f) = a + floor(f*(b-a) / 2^16), exact for the truncated form.
  logic signed [KW:0]     d_top, d_bot;
  logic signed [2*KW+1:0] p_top6, p_bot6;
  logic [KW-1:0]          c00_6, c10_6;
  logic                   v6;
  item_t                  it6;

  assign d_top = $signed({1'b0, c01}) - $signed({1'b0, c00});
  assign d_bot = $signed({1'b0, c11}) - $signed({1'b0, c10});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      it6    <= it5;
      p_top6 <= $signed({1'b0, fx5}) * d_top;
      p_bot6 <= $signed({1'b0, fx5}) * d_bot;
      c00_6  <= c00;
      c10_6  <= c10;
    end
  end

  // ---------------- S7: horizontal sums ----------------
  logic signed [KW+1:0] s_top, s_bot;
  logic [KW-1:0]        top7, bot7;
  logic                 v7;
  item_t                it7;

  assign s_top = $signed({2'b00, c00_6}) + $signed(p_top6[2*KW+1:FW]);
  assign s_bot = $signed({2'b00, c10_6}) + $signed(p_bot6[2*KW+1:FW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      it7  <= it6;
      top7 <= s_top[KW-1:0];
      bot7 <= s_bot[KW-1:0];
    end
  end

  // ---------------- S8: vertical weight product ----------------
  logic signed [KW:0]     d_v;
  logic signed [2*KW+1:0] p_v8;
  logic [KW-1:0]          top8;
  logic                   v8;
  item_t                  it8;

  assign d_v = $signed({1'b0, bot7}) - $signed({1'b0, top7});

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
    if (adv) begin
      it8  <= it7;
      p_v8 <= $signed({1'b0, it7.fy}) * d_v;
      top8 <= top7;
    end
  end

  // ---------------- S9: output register ----------------
  logic signed [KW+1:0] s_v;
  logic [KW-1:0]        pix_value;
  logic [IW-1:0]        pix_row;
  logic [IW-1:0]        pix_col;

  assign s_v = $signed({2'b00, top8}) + $signed(p_v8[2*KW+1:FW]);

  // Loads, length writes and unused codes end here without a beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= v8 && (it8.kind == rbsr_pkg::REQ_PIXEL);
    end
    if (adv) begin
      pix_value <= s_v[KW-1:0];
      pix_row   <= it8.row;
      pix_col   <= it8.col;
    end
  end

  assign pix.valid       = vo;
  assign pix.pixel_value = pix_value;
  assign pix.row_out     = pix_row;
  assign pix.col_out     = pix_col;

endmodule

// File: hw/rtl/rbsr_div.sv
// Pipelined restoring divider: (prod << 16) / dvs, one quotient bit per stage,
// split into index, next index and Q0.16 weight. Depends on rbsr_pkg.
module rbsr_div #(
  parameter int SPAN_W = $clog2(rbsr_pkg::MAX_LEN_DEF),
  parameter int PW     = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [rbsr_pkg::IDX_W+SPAN_W-1:0]   prod,
  input  logic [rbsr_pkg::STRIP_W-1:0]        dvs,
  input  logic                                sat,
  input  logic [SPAN_W-1:0]                   span,
  input  logic [PW-1:0]                       pay,
  output logic                                out_valid,
  output logic [SPAN_W-1:0]                   lo,
  output logic [SPAN_W-1:0]                   hi,
  output logic [rbsr_pkg::FRAC_W-1:0]         frac,
  output logic [PW-1:0]                       out_pay
);
  localparam int FW = rbsr_pkg::FRAC_W;
  localparam int QW = SPAN_W + FW;
  localparam int DW = rbsr_pkg::STRIP_W;
  localparam int IW = rbsr_pkg::IDX_W;

  logic          st_v    [QW];
  logic [DW-1:0] st_rem  [QW];
  logic [QW-1:0] st_q    [QW];
  logic [QW-1:0] st_bits [QW];
  logic [DW-1:0] st_dvs  [QW];
  logic          st_sat  [QW];
  logic [SPAN_W-1:0] st_span [QW];
  logic [PW-1:0] st_pay  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prem;
    logic [QW-1:0] pq;
    logic [QW-1:0] pbits;
    logic [DW-1:0] pdvs;
    logic          psat;
    logic [SPAN_W-1:0] pspan;
    logic [PW-1:0] ppay;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      // Top bits of the numerator are already below the divisor when not saturated.
      assign pv    = in_valid;
      assign prem  = DW'(prod[IW+SPAN_W-1:SPAN_W]);
      assign pq    = '0;
      assign pbits = {prod[SPAN_W-1:0], {FW{1'b0}}};
      assign pdvs  = dvs;
      assign psat  = sat;
      assign pspan = span;
      assign ppay  = pay;
    end else begin : g_next
      assign pv    = st_v[k-1];
      assign prem  = st_rem[k-1];
      assign pq    = st_q[k-1];
      assign pbits = st_bits[k-1];
      assign pdvs  = st_dvs[k-1];
      assign psat  = st_sat[k-1];
      assign pspan = st_span[k-1];
      assign ppay  = st_pay[k-1];
    end

    assign t  = {prem, pbits[QW-1]};
    assign ge = (t >= {1'b0, pdvs});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (adv) begin
        st_v[k] <= pv;
      end
      if (adv) begin
        st_rem[k]  <= ge ? DW'(t - {1'b0, pdvs}) : DW'(t);
        st_q[k]    <= {pq[QW-2:0], ge};
        st_bits[k] <= {pbits[QW-2:0], 1'b0};
        st_dvs[k]  <= pdvs;
        st_sat[k]  <= psat;
        st_span[k] <= pspan;
        st_pay[k]  <= ppay;
      end
    end
  end

  assign out_valid = st_v[QW-1];
  assign out_pay   = st_pay[QW-1];
  assign lo   = st_sat[QW-1] ? st_span[QW-1] : st_q[QW-1][QW-1:FW];
  assign hi   = st_sat[QW-1] ? st_span[QW-1] : SPAN_W'(st_q[QW-1][QW-1:FW] + 1'b1);
  assign frac = st_sat[QW-1] ? '0 : st_q[QW-1][FW-1:0];

endmodule

// File: sim/tb_ifs.sv
`timescale 1ns / 1ps
// Bench-side interface list: the request and pixel interfaces are taken from
// hw/rtl/rbsr_req_if.sv, compiled once together with the RTL.

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ragged_bilinear_strip_resampler_top: directed table, then random
// requests, each pixel checked against an in-bench bilinear predictor.
// Depends on rbsr_pkg, the interfaces and the RTL.
module tb_top;

  localparam int NCH  = rbsr_pkg::MAX_CHANNELS_DEF;
  localparam int NLEN = rbsr_pkg::MAX_LEN_DEF;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int CHW  = rbsr_pkg::CH_W;
  localparam int PSW  = rbsr_pkg::POS_W;
  localparam int KW   = rbsr_pkg::COEF_W;
  localparam int IW   = rbsr_pkg::IDX_W;
  localparam int SW   = rbsr_pkg::STRIP_W;
  localparam int NW   = rbsr_pkg::NCH_W;
  localparam int XW   = rbsr_pkg::CFG_IDX_W;
  localparam logic [1:0] REQ_NONE = 2'd3;  // unused request code

  typedef struct packed {
    logic [1:0]     kind;
    logic [CHW-1:0] ch;
    logic [PSW-1:0] pos;
    logic [KW-1:0]  val;
    logic [IW-1:0]  row;
    logic [IW-1:0]  col;
  } req_t;

  typedef struct packed {
    logic [KW-1:0] pv;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
  } pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [XW-1:0] cfg_index = '0;
  logic [SW-1:0] cfg_data = '0;

  rbsr_req_if req();
  rbsr_pix_if pix();

  ragged_bilinear_strip_resampler_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .pix(pix.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow coefficient grid, lengths and registers.
  logic [KW-1:0] shadow_coef [NCH*NLEN];
  logic [10:0]   shadow_len  [NCH];
  logic [NW-1:0] shadow_nch;
  logic [SW-1:0] shadow_w;
  logic [SW-1:0] shadow_h;

  pix_t expected_pixels[$];
  int   mismatch_count = 0;
  int   pixels_seen = 0;
  int   cycle_count = 0;
  int   long_hold = 0;  // pixel-side hold-off, counted down in its own process

  // Q.16 position idx*span/div, saturated at span with zero weight.
  function automatic void place(input int unsigned idx, input int unsigned span,
                                input int unsigned div, output int unsigned lo,
                                output int unsigned hi, output int unsigned frac);
    longint unsigned p;
    p = ((longint'(idx) * span) << 16) / div;
    if (p >= (longint'(span) << 16)) begin
      lo = span; hi = span; frac = 0;
    end else begin
      lo = 32'(p >> 16); hi = lo + 1; frac = 32'(p & 64'hFFFF);
    end
  endfunction

  function automatic int unsigned blend(input int unsigned a, input int unsigned b,
                                        input int unsigned f);
    longint unsigned s;
    s = longint'(65536 - f) * a + longint'(f) * b;
    return 32'((s >> 16) & 64'hFFFF);
  endfunction

  function automatic int unsigned coef_read(input int unsigned ch, input int unsigned p);
    if (ch >= NCH || p >= NLEN) return 0;
    return 32'(shadow_coef[ch*NLEN + p]);
  endfunction

  function automatic int unsigned span_of(input int unsigned ch);
    int unsigned l;
    if (ch >= NCH) return 2;
    l = 32'(shadow_len[ch]);
    return (l < 2) ? 2 : (l > NLEN ? NLEN : l);
  endfunction

  function automatic int unsigned sat(input int unsigned v, input int unsigned lo,
                                      input int unsigned hi);
    return (v < lo) ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned bilinear_pixel(input int unsigned row,
                                                 input int unsigned col);
    int unsigned m, w, h, ylo, yhi, fy, xlo, xhi, fx, upper, lower;
    m = sat(32'(shadow_nch), 1, NCH);
    w = sat(32'(shadow_w), 1, rbsr_pkg::STRIP_MAX);
    h = sat(32'(shadow_h), 1, rbsr_pkg::STRIP_MAX);
    if (m == 1) begin
      place(row, span_of(0) - 1, h, ylo, yhi, fy);
      return blend(coef_read(0, ylo), coef_read(0, yhi), fy);
    end
    place(row, m - 1, h, ylo, yhi, fy);
    place(col, span_of(ylo) - 1, w, xlo, xhi, fx);
    upper = blend(coef_read(ylo, xlo), coef_read(ylo, xhi), fx);
    lower = blend(coef_read(yhi, xlo), coef_read(yhi, xhi), fx);
    return blend(upper, lower, fy);
  endfunction

  // Apply one accepted beat to the shadow state, queue the pixel it causes.
  function automatic void predict_beat(input req_t r);
    pix_t e;
    case (r.kind)
      rbsr_pkg::REQ_LOAD: shadow_coef[32'(r.ch)*NLEN + 32'(r.pos)] = r.val;
      rbsr_pkg::REQ_LEN: shadow_len[r.ch] = 11'(sat(32'(r.val), 2, NLEN));
      rbsr_pkg::REQ_PIXEL: begin
        e.pv = KW'(bilinear_pixel(32'(r.row), 32'(r.col)));
        e.row = r.row;
        e.col = r.col;
        expected_pixels.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [XW-1:0] idx, input logic [SW-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rbsr_pkg::CFG_NUM_CHANNELS: shadow_nch = d[NW-1:0];
      rbsr_pkg::CFG_STRIP_WIDTH: shadow_w = d;
      rbsr_pkg::CFG_STRIP_HEIGHT: shadow_h = d;
      default: ;
    endcase
  endtask

  // Offer one beat at this edge, hold it until accepted, then maybe leave a gap.
  task automatic send_beat(input req_t r, input bit may_gap);
    int gap;
    req.valid <= 1'b1;
    {req.req_type, req.channel, req.position, req.value, req.pixel_row, req.pixel_col} <= r;
    do @(posedge clk); while (!req.ready);
    predict_beat(r);
    gap = 0;
    if (may_gap) begin
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 9) ? int'($urandom_range(1, 3)) :
                                         int'($urandom_range(10, 40));
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_idle();
    req.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    // Loads may still be in flight; let the pipeline settle.
    repeat (64 + 2 * 13 + 42) @(posedge clk);
  endtask

  function automatic req_t mk(input logic [1:0] k, input int ch, input int pos,
                              input int val, input int row, input int col);
    req_t r;
    r.kind = k; r.ch = CHW'(ch); r.pos = PSW'(pos); r.val = KW'(val);
    r.row = IW'(row); r.col = IW'(col);
    return r;
  endfunction

  // Random beat: mostly loads into the low part of each row and pixels.
  function automatic req_t random_beat();
    req_t r;
    int sel;
    r = $bits(req_t)'({$urandom, $urandom});
    sel = int'($urandom_range(0, 99));
    if (sel < 30) begin
      r.kind = rbsr_pkg::REQ_LOAD;
      if ($urandom_range(0, 3) != 0) r.pos = PSW'($urandom_range(0, 40));
    end else if (sel < 40) begin
      r.kind = rbsr_pkg::REQ_LEN;
      if ($urandom_range(0, 3) != 0) r.val = KW'($urandom_range(0, 40));
    end else if (sel < 97) begin
      r.kind = rbsr_pkg::REQ_PIXEL;
      if ($urandom_range(0, 2) != 0) begin
        r.row = IW'($urandom_range(0, 300));
        r.col = IW'($urandom_range(0, 300));
      end
    end else begin
      r.kind = REQ_NONE;
    end
    return r;
  endfunction

  // Directed table; expected pixel typed in where it is obvious (zero store, extremes).
  typedef struct {
    req_t r;
    bit   has_exp;
    int   exp_pv;
  } row_t;
  row_t table_rows[$];

  task automatic add_row(input req_t r, input bit he, input int ev);
    row_t t;
    t.r = r; t.has_exp = he; t.exp_pv = ev;
    table_rows.push_back(t);
  endtask

  // Pixel side: accept with random stalls, compare against oldest expectation.
  initial begin
    pix.ready = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (!rst && pix.valid && pix.ready) begin
        pix_t e;
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected pixel row %0d col %0d value %0d",
                     pix.row_out, pix.col_out, pix.pixel_value);
        end else begin
          e = expected_pixels.pop_front();
          pixels_seen++;
          if (e.pv !== pix.pixel_value || e.row !== pix.row_out || e.col !== pix.col_out) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("pixel mismatch: exp %0d r%0d c%0d got %0d r%0d c%0d",
                       e.pv, e.row, e.col, pix.pixel_value, pix.row_out, pix.col_out);
          end
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        pix.ready <= 1'b0;
      end else if (pixels_seen < 40 || $urandom_range(0, 9) < 7) begin
        pix.ready <= 1'b1;
      end else begin
        pix.ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout with %0d pixels outstanding", expected_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int i, total;
    for (i = 0; i < NCH*NLEN; i++) shadow_coef[i] = '0;
    for (i = 0; i < NCH; i++) shadow_len[i] = 11'd2;
    shadow_nch = rbsr_pkg::NUM_CHANNELS_RST;
    shadow_w = rbsr_pkg::STRIP_SIZE_RST;
    shadow_h = rbsr_pkg::STRIP_SIZE_RST;
    req.valid = 1'b0;
    {req.req_type, req.channel, req.position, req.value, req.pixel_row, req.pixel_col} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset store reads zero; extremes of every field; bad type ignored.
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 0, 0), 1, 0);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 63, 1023, 65535, 4095, 4095), 1, 0);
    add_row(mk(REQ_NONE, 63, 1023, 65535, 4095, 4095), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LOAD, 0, 0, 65535, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LOAD, 0, 1, 1000, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 0, 0), 1, 65535);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 128, 7), 0, 0);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 4095, 0), 1, 1000);
    add_row(mk(rbsr_pkg::REQ_LOAD, 63, 1023, 65535, 4095, 4095), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LEN, 63, 0, 65535, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LEN, 0, 0, 0, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LEN, 1, 0, 5, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LOAD, 1, 2, 12345, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LEN, 0, 0, 9, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_LOAD, 0, 8, 4000, 0, 0), 0, 0);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 200, 3000), 0, 0);
    add_row(mk(rbsr_pkg::REQ_PIXEL, 0, 0, 0, 255, 0), 0, 0);
    for (i = 0; i < table_rows.size(); i++) begin
      send_beat(table_rows[i].r, 1'b0);
      if (table_rows[i].has_exp &&
          int'(expected_pixels[expected_pixels.size()-1].pv) != table_rows[i].exp_pv) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("table row %0d: predictor gives %0d, table says %0d", i,
                   expected_pixels[expected_pixels.size()-1].pv, table_rows[i].exp_pv);
      end
    end
    drain_idle();

    // Random phases across register settings, extremes included.
    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(rbsr_pkg::CFG_NUM_CHANNELS, 13'd2);
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, 13'd1);
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, 13'd1); end
        1: begin write_reg(rbsr_pkg::CFG_NUM_CHANNELS, 13'd64);
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, 13'd4096);
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, 13'd4096); end
        2: begin write_reg(rbsr_pkg::CFG_NUM_CHANNELS, 13'd127);
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, 13'd8191);
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, 13'd0); end
        3: begin write_reg(rbsr_pkg::CFG_NUM_CHANNELS, 13'd0);
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, 13'd0);
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, 13'd300); end
        4: begin write_reg(rbsr_pkg::CFG_NUM_CHANNELS, 13'd1);
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, 13'd37);
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, 13'd4097); end
        default: begin
                 write_reg(rbsr_pkg::CFG_NUM_CHANNELS, SW'($urandom_range(2, 64)));
                 write_reg(rbsr_pkg::CFG_STRIP_WIDTH, SW'($urandom_range(1, 300)));
                 write_reg(rbsr_pkg::CFG_STRIP_HEIGHT, SW'($urandom_range(1, 300))); end
      endcase
      // Phase 1: long pixel hold-off while the sender keeps offering beats.
      if (ph == 1) long_hold = 400;
      for (i = 0; i < 105; i++) begin
        send_beat(random_beat(), ph != 1);
        total++;
      end
      drain_idle();
    end

    $display("covered %0d random beats over 6 register settings, %0d pixels checked",
             total, pixels_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: ragged_bilinear_strip_resampler_top.f
hw/rtl/rbsr_pkg.sv
hw/rtl/rbsr_req_if.sv
hw/rtl/rbsr_div.sv
hw/rtl/ragged_bilinear_strip_resampler_top.sv
sim/tb_ifs.sv
sim/tb_top.sv
